// ===== design/mbs_pkg.sv =====
// package for the multipart boundary stripper: word types, codes and sizes
// used by the cell chain, the result queue and the top level; no dependencies
`timescale 1ns / 1ps

package mbs_pkg;

	localparam int unsigned MAX_PATTERN_DEF = 128;
	// position width fixed by the largest supported window (256)
	localparam int unsigned POS_W = 9;
	localparam int unsigned LEN_RESET = 2;
	localparam int unsigned LEN_MIN = 2;

	typedef logic [POS_W-1:0] pos_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_FOUND = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef struct packed {
		logic cmd;
		logic [6:0] pattern_index;
		logic [7:0] byte_value;
		logic end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic last_of_run;
	} out_word_t;

	// broadcast to every cell of the window chain
	typedef struct packed {
		logic step;
		logic shift;
		pos_t wr_pos;
		logic [7:0] data;
		logic pat_we;
		pos_t pat_idx;
		pos_t length;
	} cell_ctrl_t;

	// results produced by one accepted word, up to two
	typedef struct packed {
		logic [1:0] n;
		out_word_t r0;
		out_word_t r1;
	} push_t;

endpackage

// ===== design/mbs_cell.sv =====
// one window cell: holds one window byte and one boundary pattern byte
// depends on mbs_pkg; takes its neighbor's byte when the window shifts
`timescale 1ns / 1ps

module mbs_cell #(
	parameter int unsigned CELL_IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input mbs_pkg::cell_ctrl_t ctrl,
	input logic [7:0] nb_byte,
	output logic [7:0] win_byte,
	output logic eq
);
	import mbs_pkg::*;

	localparam pos_t MY_POS = pos_t'(CELL_IDX);

	logic [7:0] win_q;
	logic [7:0] pat_q;
	logic [7:0] win_d;

	always_comb begin
		win_d = win_q;
		if (ctrl.step) begin
			if (ctrl.shift) begin
				win_d = nb_byte;
			end
			if (ctrl.wr_pos == MY_POS) begin
				win_d = ctrl.data;
			end
		end
	end

	// cells past the active length never block a match
	assign eq = (MY_POS >= ctrl.length) || (win_d == pat_q);
	assign win_byte = win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 8'd0;
		end else begin
			win_q <= win_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pat_we && ctrl.pat_idx == MY_POS) begin
			pat_q <= ctrl.data;
		end
	end

endmodule

// ===== design/mbs_result_fifo.sv =====
// four-entry result queue between the window logic and the output channel
// depends on mbs_pkg; takes up to two words per cycle, gives one
`timescale 1ns / 1ps

module mbs_result_fifo (
	input logic clk,
	input logic arst_n,
	input mbs_pkg::push_t push,
	output logic room2,
	output logic out_valid,
	input logic out_stall,
	output mbs_pkg::out_word_t out_data
);
	import mbs_pkg::*;

	out_word_t ent_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic pop;

	assign out_valid = (cnt_q != 3'd0);
	assign pop = out_valid && !out_stall;
	assign out_data = ent_q[rd_q];
	assign room2 = (cnt_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			ent_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			ent_q[wr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 2'd0;
			rd_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q <= wr_q + push.n;
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push.n} - {2'b00, pop};
		end
	end

endmodule

// ===== design/multipart_boundary_stripper.sv =====
// multipart boundary stripper: a chain of window cells compares the last
// pattern_length body bytes against the loaded boundary in the accept cycle.
// results are registered in the result queue before they reach the output side
// throughput: one word per cycle while the output side takes a word per cycle;
// stall rises when the four-entry result queue has fewer than two free slots
// reset: window empty, run not finished, length 2, queue empty; pattern not reset
`timescale 1ns / 1ps

module multipart_boundary_stripper #(
	parameter int unsigned MAX_PATTERN = mbs_pkg::MAX_PATTERN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input mbs_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output mbs_pkg::out_word_t out_data,
	input logic cfg_wen,
	input logic [7:0] cfg_wdata
);
	import mbs_pkg::*;

	localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

	logic [LW-1:0] len_q;
	logic [LW-1:0] fill_q;
	logic fin_q;

	logic room2;
	logic in_take;
	logic body;
	logic idx_ok;
	logic load;
	logic full;
	logic will_fill;
	logic match;
	logic ends;
	logic [LW-1:0] fill_inc;
	logic [LW-1:0] len_cfg;
	pos_t cfg_ext;
	cell_ctrl_t ctrl;
	push_t push;
	out_word_t res_data;
	out_word_t res_mark;

	logic [7:0] win [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] eq;

	assign in_stall = !room2;
	assign in_take = in_valid && room2;
	assign idx_ok = pos_t'(in_data.pattern_index) < pos_t'(MAX_PATTERN);
	assign load = in_take && (in_data.cmd == CMD_LOAD) && idx_ok;
	assign body = in_take && (in_data.cmd == CMD_DATA) && !fin_q;

	assign full = (fill_q == len_q);
	assign fill_inc = fill_q + LW'(1);
	assign will_fill = full || (fill_inc == len_q);
	assign match = will_fill && (&eq);
	assign ends = match || in_data.end_of_stream;

	always_comb begin
		ctrl.step = body;
		ctrl.shift = full;
		ctrl.wr_pos = full ? pos_t'(len_q - LW'(1)) : pos_t'(fill_q);
		ctrl.data = in_data.byte_value;
		ctrl.pat_we = load;
		ctrl.pat_idx = pos_t'(in_data.pattern_index);
		ctrl.length = pos_t'(len_q);
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
			logic [7:0] nb;
			if (gi == MAX_PATTERN - 1) begin : g_top
				assign nb = 8'd0;
			end else begin : g_mid
				assign nb = win[gi + 1];
			end
			mbs_cell #(
				.CELL_IDX(gi)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctrl(ctrl),
				.nb_byte(nb),
				.win_byte(win[gi]),
				.eq(eq[gi])
			);
		end
	endgenerate

	always_comb begin
		res_data.out_byte = win[0];
		res_data.kind = KIND_DATA;
		res_data.last_of_run = !ends;
		res_mark.out_byte = 8'd0;
		res_mark.kind = match ? KIND_FOUND : KIND_ERROR;
		res_mark.last_of_run = 1'b1;
		push.r0 = full ? res_data : res_mark;
		push.r1 = res_mark;
		push.n = 2'd0;
		if (body) begin
			push.n = {1'b0, full} + {1'b0, ends};
		end
	end

	// clamp the written length into the supported range
	always_comb begin
		cfg_ext = pos_t'(cfg_wdata);
		priority if (cfg_ext < pos_t'(LEN_MIN)) begin
			len_cfg = LW'(LEN_MIN);
		end else if (cfg_ext > pos_t'(MAX_PATTERN)) begin
			len_cfg = LW'(MAX_PATTERN);
		end else begin
			len_cfg = LW'(cfg_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LW'(LEN_RESET);
			fill_q <= '0;
			fin_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				len_q <= len_cfg;
				fill_q <= '0;
			end else if (load) begin
				fill_q <= '0;
				fin_q <= 1'b0;
			end else if (body) begin
				if (ends) begin
					fill_q <= '0;
					fin_q <= 1'b1;
				end else if (!full) begin
					fill_q <= fill_inc;
				end
			end
		end
	end

	mbs_result_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room2(room2),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for multipart_boundary_stripper: drives pattern loads and
// body bytes, predicts the byte stream and run markers, checks every result word
// depends on mbs_pkg and the multipart_boundary_stripper top level
`timescale 1ns / 1ps

module testbench;

	import mbs_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEM_GOAL = 1200;
	localparam int CALM_AFTER = 1050;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_data;
	logic cfg_wen = 1'b0;
	logic [7:0] cfg_wdata = '0;

	// stimulus and checking state
	in_word_t words_to_send[$];
	out_word_t results_due[$];
	bit took_word = 1'b0;
	bit calm = 1'b0;
	int gap_odds = 0;
	int stall_odds = 0;
	int send_gap = 0;
	int stall_left = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int words_taken = 0;
	int data_seen = 0;
	int found_seen = 0;
	int error_seen = 0;
	int items_queued = 0;

	// predictor state
	bit [7:0] win_bytes[MAX_PATTERN_DEF];
	bit [7:0] bnd_bytes[MAX_PATTERN_DEF];
	int unsigned win_fill = 0;
	int unsigned win_len = LEN_RESET;
	bit run_over = 1'b0;

	// generator view of the boundary
	bit [7:0] gen_bnd[MAX_PATTERN_DEF];
	bit gen_written[MAX_PATTERN_DEF];
	int unsigned gen_len = LEN_RESET;
	bit gen_open = 1'b0;

	multipart_boundary_stripper i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic int unsigned eff_length(input logic [7:0] v);
		int unsigned u;
		u = 32'(v);
		if (u < LEN_MIN) return LEN_MIN;
		if (u > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
		return u;
	endfunction

	function automatic void strip_predict(input in_word_t w);
		out_word_t r[2];
		int n;
		bit hit;
		n = 0;
		if (w.cmd == CMD_LOAD) begin
			bnd_bytes[w.pattern_index] = w.byte_value;
			run_over = 1'b0;
			win_fill = 0;
			return;
		end
		if (run_over) return;
		if (win_fill >= win_len) begin
			r[n].out_byte = win_bytes[0];
			r[n].kind = KIND_DATA;
			r[n].last_of_run = 1'b0;
			n++;
			for (int i = 0; i + 1 < win_len; i++) win_bytes[i] = win_bytes[i + 1];
			win_fill = win_len - 1;
		end
		win_bytes[win_fill] = w.byte_value;
		win_fill++;
		hit = (win_fill == win_len);
		for (int i = 0; i < win_len; i++) begin
			if (win_bytes[i] != bnd_bytes[i]) hit = 1'b0;
		end
		// a match wins over end of stream
		if (hit || w.end_of_stream) begin
			r[n].out_byte = 8'd0;
			r[n].kind = hit ? KIND_FOUND : KIND_ERROR;
			r[n].last_of_run = 1'b0;
			n++;
			win_fill = 0;
			run_over = 1'b1;
		end
		if (n > 0) r[n - 1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++) results_due.push_back(r[i]);
	endfunction

	// predictor update and result check
	always @(posedge clk) begin : watch
		out_word_t seen;
		out_word_t want;
		if (arst_n) begin
			if (cfg_wen) begin
				win_len = eff_length(cfg_wdata);
				win_fill = 0;
			end
			if (in_valid && !in_stall) begin
				strip_predict(in_data);
				words_taken++;
				took_word = 1'b1;
			end
			if (out_valid && !out_stall) begin
				seen = out_data;
				case (seen.kind)
					KIND_DATA: data_seen++;
					KIND_FOUND: found_seen++;
					default: error_seen++;
				endcase
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: byte %h kind %0d last %b",
							seen.out_byte, seen.kind, seen.last_of_run);
				end else begin
					want = results_due.pop_front();
					if (seen.out_byte !== want.out_byte || seen.kind !== want.kind ||
							seen.last_of_run !== want.last_of_run) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch at %0t: expected byte %h kind %0d last %b",
								$realtime, want.out_byte, want.kind, want.last_of_run);
							$display("  got byte %h kind %0d last %b",
								seen.out_byte, seen.kind, seen.last_of_run);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL multipart_boundary_stripper");
			$finish;
		end
	end

	// input driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !took_word) begin
			// stalled word stays put
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap--;
		end else if (words_to_send.size() != 0) begin
			in_data <= words_to_send.pop_front();
			in_valid <= 1'b1;
			if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
				send_gap = $urandom_range(1, 4);
		end else begin
			in_valid <= 1'b0;
		end
		took_word = 1'b0;
	end

	// output stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic queue_load(input int unsigned idx, input logic [7:0] val);
		in_word_t w;
		w.cmd = CMD_LOAD;
		w.pattern_index = idx[6:0];
		w.byte_value = val;
		w.end_of_stream = 1'($urandom_range(0, 1));
		words_to_send.push_back(w);
		gen_bnd[idx[6:0]] = val;
		gen_written[idx[6:0]] = 1'b1;
		gen_open = 1'b1;
		items_queued++;
	endtask

	task automatic queue_body(input logic [7:0] val, input bit eos, input bit counted);
		in_word_t w;
		w.cmd = CMD_DATA;
		w.pattern_index = 7'($urandom_range(0, 127));
		w.byte_value = val;
		w.end_of_stream = eos;
		words_to_send.push_back(w);
		if (counted) items_queued++;
	endtask

	task automatic wait_idle(input int settle);
		while (words_to_send.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		// a word that gives no result may still be in flight
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_length(input logic [7:0] v);
		wait_idle(4);
		@(negedge clk);
		cfg_wdata <= v;
		cfg_wen <= 1'b1;
		@(negedge clk);
		cfg_wen <= 1'b0;
		gen_len = eff_length(v);
	endtask

	// every compared pattern entry must have been loaded
	task automatic ensure_pattern();
		for (int i = 0; i < gen_len; i++) begin
			if (!gen_written[i]) begin
				if (i == 0) queue_load(i, 8'h0D);
				else if (i == 1) queue_load(i, 8'h0A);
				else if (i < 4) queue_load(i, 8'h2D);
				else queue_load(i, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic restart_load();
		int unsigned idx;
		if ($urandom_range(0, 3) == 0) idx = $urandom_range(0, 127);
		else idx = $urandom_range(0, gen_len - 1);
		if (idx < 2 && $urandom_range(0, 7) != 0) queue_load(idx, gen_bnd[idx]);
		else queue_load(idx, 8'($urandom_range(0, 255)));
	endtask

	task automatic queue_run();
		int unsigned k;
		int unsigned n;
		int unsigned m;
		k = $urandom_range(0, 9);
		if (k == 9) begin
			// noise: random commands, indexes and end flags
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 1))
					queue_load($urandom_range(0, 127), 8'($urandom_range(0, 255)));
				else
					queue_body(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
			end
			gen_open = 1'b0;
			return;
		end
		if (!gen_open || $urandom_range(0, 3) == 0) restart_load();
		if (k <= 5) begin
			n = $urandom_range(0, gen_len > 16 ? 4 : 12);
			repeat (n) queue_body(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			for (int i = 0; i < gen_len; i++)
				queue_body(gen_bnd[i], i == gen_len - 1 && $urandom_range(0, 3) == 0, 1'b1);
			gen_open = 1'b0;
			// trailing words are dropped by the block
			repeat ($urandom_range(0, 2))
				queue_body(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
		end else if (k <= 7) begin
			n = $urandom_range(1, 10);
			for (int i = 1; i <= n; i++) queue_body(8'($urandom_range(0, 255)), i == n, 1'b1);
			gen_open = 1'b0;
		end else begin
			// boundary prefix broken by one wrong byte
			repeat ($urandom_range(0, 4)) queue_body(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			m = $urandom_range(1, gen_len - 1);
			for (int i = 0; i < m; i++) queue_body(gen_bnd[i], 1'b0, 1'b1);
			queue_body(gen_bnd[m] ^ 8'($urandom_range(1, 255)), 1'b0, 1'b1);
			if ($urandom_range(0, 1)) begin
				queue_body(8'($urandom_range(0, 255)), 1'b1, 1'b1);
				gen_open = 1'b0;
			end
		end
	endtask

	initial begin
		logic [7:0] fixed_lens[7];
		logic [7:0] v;
		int phase;
		int start;
		int runs;
		int r;
		fixed_lens = '{8'd0, 8'd1, 8'd3, 8'd128, 8'd255, 8'd129, 8'd4};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: boundary is CR LF at the reset length
		queue_load(0, 8'h0D);
		queue_load(1, 8'h0A);
		queue_body(8'h00, 1'b0, 1'b1);
		queue_body(8'hFF, 1'b0, 1'b1);
		queue_body(8'h41, 1'b0, 1'b1);
		queue_body(8'h0D, 1'b0, 1'b1);
		queue_body(8'h0A, 1'b0, 1'b1);
		queue_body(8'h55, 1'b0, 1'b1);
		// restart, end of stream on a short window
		queue_load(1, 8'h0A);
		queue_body(8'h0D, 1'b1, 1'b1);
		queue_body(8'h11, 1'b0, 1'b1);
		// match on the final byte
		queue_load(127, 8'hFF);
		queue_body(8'h0D, 1'b0, 1'b1);
		queue_body(8'h0A, 1'b1, 1'b1);
		// full window then end of stream
		queue_load(0, 8'h0D);
		queue_body(8'h01, 1'b0, 1'b1);
		queue_body(8'h02, 1'b0, 1'b1);
		queue_body(8'h03, 1'b1, 1'b1);
		// leave a run open across the next length write
		queue_load(0, 8'h0D);
		queue_body(8'h33, 1'b0, 1'b1);
		queue_body(8'h44, 1'b0, 1'b1);
		queue_body(8'h0D, 1'b0, 1'b1);
		gen_open = 1'b1;

		phase = 0;
		while (items_queued < ITEM_GOAL) begin
			if (phase < 7) begin
				v = fixed_lens[phase];
			end else begin
				r = $urandom_range(0, 19);
				if (r < 14) v = 8'($urandom_range(2, 10));
				else if (r < 17) v = 8'($urandom_range(11, 40));
				else v = 8'($urandom_range(0, 255));
			end
			if (items_queued >= CALM_AFTER) calm = 1'b1;
			gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
			stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
			write_length(v);
			ensure_pattern();
			start = items_queued;
			runs = 0;
			while (items_queued - start < 90 && !(gen_len > 40 && runs >= 2)) begin
				queue_run();
				runs++;
			end
			phase++;
		end

		wait_idle(8);
		if (results_due.size() != 0) begin
			$display("%0d results never arrived", results_due.size());
			mismatches += results_due.size();
		end
		$display("%0d words, %0d lengths: %0d bytes out, %0d found, %0d ended early",
			words_taken, phase, data_seen, found_seen, error_seen);
		$display("%0d cycles, %0d mismatches", cycle_count, mismatches);
		if (mismatches == 0)
			$display("PASS multipart_boundary_stripper");
		else
			$display("FAIL multipart_boundary_stripper");
		$finish;
	end

endmodule
